// ===== design/qmru_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the quaternion multiply and rotate unit.
package qmru_pkg;

   // Fixed-point format of every component.
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS = 14;

   // Full product and accumulator widths.
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int ACC_WIDTH = 2 * DATA_WIDTH + 3;

   // Quaternion components and result components.
   localparam int NUM_COMP = 4;
   localparam int NUM_RES = 9;

   // Stream widths.
   localparam int REQ_TDATA_WIDTH = ((2 * NUM_COMP * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = ((NUM_RES * DATA_WIDTH + 7) / 8) * 8;
   localparam int REQ_TUSER_WIDTH = 2;
   localparam int RSP_TUSER_WIDTH = 1;

   typedef logic [REQ_TUSER_WIDTH-1:0] op_type;

   // Operation codes.
   localparam op_type OP_PRODUCT = 2'd0;
   localparam op_type OP_ROTATE = 2'd1;
   localparam op_type OP_MATRIX = 2'd2;
   localparam op_type OP_NONE = 2'd3;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [ACC_WIDTH-1:0] acc_type;

   typedef data_type quat_type [NUM_COMP];
   typedef data_type res_vec_type [NUM_RES];
   typedef prod_type prod_arr_type [NUM_COMP][NUM_COMP];
   typedef acc_type acc_vec_type [NUM_COMP];
   typedef acc_type acc_res_type [NUM_RES];

   typedef struct packed {
      logic     sat;
      data_type val;
   } rsat_type;

   // Rounding bias, clamp limits and the constant one at product scale.
   localparam acc_type ROUND_BIAS = acc_type'(64'sd1 <<< (FRAC_BITS - 1));
   localparam acc_type SAT_MAX = acc_type'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam acc_type SAT_MIN = acc_type'(-(64'sd1 <<< (DATA_WIDTH - 1)));
   localparam acc_type ACC_ONE = acc_type'(64'sd1 <<< (2 * FRAC_BITS));

   // Sign-extend a full product to accumulator width.
   function automatic acc_type widen(input prod_type p);
      return acc_type'(p);
   endfunction

   // Hamilton product sums from the table of products p[i] * q[j].
   function automatic acc_vec_type ham_sums(input prod_arr_type m);
      acc_vec_type s;
      s[0] = widen(m[0][0]) - widen(m[1][1]) - widen(m[2][2]) - widen(m[3][3]);
      s[1] = widen(m[0][1]) + widen(m[1][0]) + widen(m[2][3]) - widen(m[3][2]);
      s[2] = widen(m[0][2]) - widen(m[1][3]) + widen(m[2][0]) + widen(m[3][1]);
      s[3] = widen(m[0][3]) + widen(m[1][2]) - widen(m[2][1]) + widen(m[3][0]);
      return s;
   endfunction

   // Hamilton product with the conjugate of q; the vector part of q is negated
   // in the sums so that the most negative component needs no extra bit.
   function automatic acc_vec_type ham_conj_sums(input prod_arr_type m);
      acc_vec_type s;
      s[0] = widen(m[0][0]) + widen(m[1][1]) + widen(m[2][2]) + widen(m[3][3]);
      s[1] = widen(m[1][0]) - widen(m[0][1]) - widen(m[2][3]) + widen(m[3][2]);
      s[2] = widen(m[2][0]) - widen(m[0][2]) + widen(m[1][3]) - widen(m[3][1]);
      s[3] = widen(m[3][0]) - widen(m[0][3]) - widen(m[1][2]) + widen(m[2][1]);
      return s;
   endfunction

   // Rotation matrix entry: optional one plus or minus twice each product.
   function automatic acc_type mat_entry(input logic with_one, input prod_type t1,
                                         input logic neg1, input prod_type t2,
                                         input logic neg2);
      acc_type s;
      acc_type u1;
      acc_type u2;
      u1 = widen(t1) <<< 1;
      u2 = widen(t2) <<< 1;
      s = with_one ? ACC_ONE : '0;
      s = neg1 ? s - u1 : s + u1;
      s = neg2 ? s - u2 : s + u2;
      return s;
   endfunction

   // Round to nearest with ties upward, drop the fraction bits and clamp.
   function automatic rsat_type round_sat(input acc_type a);
      acc_type  biased;
      acc_type  shifted;
      rsat_type r;
      biased = a + ROUND_BIAS;
      shifted = biased >>> FRAC_BITS;
      r.sat = 1'b0;
      r.val = shifted[DATA_WIDTH-1:0];
      priority if (shifted > SAT_MAX) begin
         r.sat = 1'b1;
         r.val = SAT_MAX[DATA_WIDTH-1:0];
      end else if (shifted < SAT_MIN) begin
         r.sat = 1'b1;
         r.val = SAT_MIN[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/qmru_prod_array.sv =====
`timescale 1ns / 1ps
// Registered array of all sixteen component products of two quaternions.
module qmru_prod_array
   import qmru_pkg::*;
(
   input  logic         clock,
   input  logic         en,
   input  quat_type     p,
   input  quat_type     q,
   output prod_arr_type prod_ff
);

   prod_arr_type prod_in;

   // One signed multiplier per pair of components.
   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         for (int j = 0; j < NUM_COMP; j++) begin
            prod_in[i][j] = prod_type'(p[i]) * prod_type'(q[j]);
         end
      end
   end

   // Products advance only when the stage may move.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== design/quaternion_multiply_rotate_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output accepts, through six register
// stages (multiply, sum, round, multiply, sum, round and select); a stalled output holds
// its own stage and every full stage behind it while earlier bubbles keep filling.
// Reset is synchronous and clears the stage valid bits; data registers are not reset.
// Top level of the quaternion multiply and rotate unit.
module quaternion_multiply_rotate_unit
   import qmru_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from the lowest bit up
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // req_type
   input  logic [REQ_TUSER_WIDTH-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // res_0 through res_8 from the lowest bit up
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // sat_flag
   output logic [RSP_TUSER_WIDTH-1:0] rsp_tuser
);

   localparam int NUM_STAGES = 6;
   localparam int ST_PROD1 = 0;
   localparam int ST_SUM1 = 1;
   localparam int ST_RND1 = 2;
   localparam int ST_PROD2 = 3;
   localparam int ST_SUM2 = 4;
   localparam int ST_OUT = 5;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] stage_en;

   quat_type     in_a;
   quat_type     in_b;
   quat_type     q1;
   op_type       in_op;

   prod_arr_type prod1;
   op_type       op1_ff;
   quat_type     a1_ff;

   acc_vec_type  ham1;
   acc_res_type  sum1_in;
   acc_res_type  sum1_ff;
   op_type       op2_ff;
   quat_type     a2_ff;

   res_vec_type  rnd1_in;
   logic         sat1_in;
   res_vec_type  rnd1_ff;
   logic         sat1_ff;
   op_type       op3_ff;
   quat_type     a3_ff;

   quat_type     t_q;
   prod_arr_type prod2;
   res_vec_type  rnd4_ff;
   logic         sat4_ff;
   op_type       op4_ff;

   acc_vec_type  sum2_ff;
   res_vec_type  rnd5_ff;
   logic         sat5_ff;
   op_type       op5_ff;

   rsat_type                      rot_rs;
   data_type                      rot_val [NUM_COMP];
   logic                          rot_sat;
   res_vec_type                   res_sel;
   logic                          sat_sel;
   logic [NUM_RES*DATA_WIDTH-1:0] rsp_data_in;
   logic [NUM_RES*DATA_WIDTH-1:0] rsp_data_ff;
   logic                          rsp_sat_ff;

   // A stage may load when it is empty or when the stage after it moves.
   always_comb begin
      stage_en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   end

   // Valid bits travel with the data.
   always_comb begin
      vld_in[0] = stage_en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = stage_en[ST_PROD1];
   assign rsp_tvalid = vld_ff[ST_OUT];

   // Unpack the request.
   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         in_a[i] = req_tdata[i*DATA_WIDTH +: DATA_WIDTH];
         in_b[i] = req_tdata[(NUM_COMP+i)*DATA_WIDTH +: DATA_WIDTH];
      end
      in_op = req_tuser[REQ_TUSER_WIDTH-1:0];
   end

   // Second operand of the first multiply: b, the pure vector of b, or a itself.
   always_comb begin
      unique case (in_op)
         OP_PRODUCT: q1 = in_b;
         OP_ROTATE: begin
            q1 = in_b;
            q1[0] = '0;
         end
         OP_MATRIX: q1 = in_a;
         OP_NONE: q1 = in_b;
      endcase
   end

   // Stage one: first product array.
   qmru_prod_array u_prod1 (
      .clock   (clock),
      .en      (stage_en[ST_PROD1]),
      .p       (in_a),
      .q       (q1),
      .prod_ff (prod1)
   );

   always_ff @(posedge clock) begin
      if (stage_en[ST_PROD1]) begin
         op1_ff <= in_op;
         a1_ff <= in_a;
      end
   end

   // Stage two: Hamilton sums or the nine matrix entries.
   always_comb begin
      ham1 = ham_sums(prod1);
      for (int i = 0; i < NUM_RES; i++) begin
         sum1_in[i] = '0;
      end
      if (op1_ff == OP_MATRIX) begin
         sum1_in[0] = mat_entry(1'b1, prod1[2][2], 1'b1, prod1[3][3], 1'b1);
         sum1_in[1] = mat_entry(1'b0, prod1[1][2], 1'b0, prod1[0][3], 1'b1);
         sum1_in[2] = mat_entry(1'b0, prod1[1][3], 1'b0, prod1[0][2], 1'b0);
         sum1_in[3] = mat_entry(1'b0, prod1[1][2], 1'b0, prod1[0][3], 1'b0);
         sum1_in[4] = mat_entry(1'b1, prod1[1][1], 1'b1, prod1[3][3], 1'b1);
         sum1_in[5] = mat_entry(1'b0, prod1[2][3], 1'b0, prod1[0][1], 1'b1);
         sum1_in[6] = mat_entry(1'b0, prod1[1][3], 1'b0, prod1[0][2], 1'b1);
         sum1_in[7] = mat_entry(1'b0, prod1[2][3], 1'b0, prod1[0][1], 1'b0);
         sum1_in[8] = mat_entry(1'b1, prod1[1][1], 1'b1, prod1[2][2], 1'b1);
      end else begin
         for (int i = 0; i < NUM_COMP; i++) begin
            sum1_in[i] = ham1[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SUM1]) begin
         sum1_ff <= sum1_in;
         op2_ff <= op1_ff;
         a2_ff <= a1_ff;
      end
   end

   // Stage three: round and clamp every lane; unused lanes are zero.
   always_comb begin
      rsat_type rs;
      sat1_in = 1'b0;
      for (int i = 0; i < NUM_RES; i++) begin
         rs = round_sat(sum1_ff[i]);
         rnd1_in[i] = rs.val;
         sat1_in = sat1_in | rs.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_RND1]) begin
         rnd1_ff <= rnd1_in;
         sat1_ff <= sat1_in;
         op3_ff <= op2_ff;
         a3_ff <= a2_ff;
      end
   end

   // Stage four: rounded intermediate t times a, for the conjugate product.
   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         t_q[i] = rnd1_ff[i];
      end
   end

   qmru_prod_array u_prod2 (
      .clock   (clock),
      .en      (stage_en[ST_PROD2]),
      .p       (t_q),
      .q       (a3_ff),
      .prod_ff (prod2)
   );

   always_ff @(posedge clock) begin
      if (stage_en[ST_PROD2]) begin
         rnd4_ff <= rnd1_ff;
         sat4_ff <= sat1_ff;
         op4_ff <= op3_ff;
      end
   end

   // Stage five: sums of t * conj(a).
   always_ff @(posedge clock) begin
      if (stage_en[ST_SUM2]) begin
         sum2_ff <= ham_conj_sums(prod2);
         rnd5_ff <= rnd4_ff;
         sat5_ff <= sat4_ff;
         op5_ff <= op4_ff;
      end
   end

   // Stage six: round the rotation, including its scalar part for the flag.
   always_comb begin
      rot_sat = 1'b0;
      for (int i = 0; i < NUM_COMP; i++) begin
         rot_rs = round_sat(sum2_ff[i]);
         rot_val[i] = rot_rs.val;
         rot_sat = rot_sat | rot_rs.sat;
      end
   end

   // Pick the result by operation.
   always_comb begin
      for (int i = 0; i < NUM_RES; i++) begin
         res_sel[i] = '0;
      end
      sat_sel = 1'b0;
      unique case (op5_ff)
         OP_PRODUCT: begin
            for (int i = 0; i < NUM_COMP; i++) begin
               res_sel[i] = rnd5_ff[i];
            end
            sat_sel = sat5_ff;
         end
         OP_ROTATE: begin
            for (int i = 0; i < NUM_COMP - 1; i++) begin
               res_sel[i] = rot_val[i+1];
            end
            sat_sel = sat5_ff | rot_sat;
         end
         OP_MATRIX: begin
            res_sel = rnd5_ff;
            sat_sel = sat5_ff;
         end
         OP_NONE: begin
            sat_sel = 1'b0;
         end
      endcase
      for (int i = 0; i < NUM_RES; i++) begin
         rsp_data_in[i*DATA_WIDTH +: DATA_WIDTH] = res_sel[i];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_sat_ff <= sat_sel;
      end
   end

   assign rsp_tdata = RSP_TDATA_WIDTH'(rsp_data_ff);
   assign rsp_tuser = RSP_TUSER_WIDTH'(rsp_sat_ff);

`ifndef NO_ASSERTIONS
   // An accepted request always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[ST_PROD1])
      else $error("accepted request did not enter the pipeline");

   // A held stage keeps its request.
   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_PROD2] && !stage_en[ST_PROD2]) |=> vld_ff[ST_PROD2])
      else $error("stalled stage dropped its request");

   // Requests in flight change only by accepts and deliveries.
   a_count_conserved: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(vld_ff) == $past($countones(vld_ff))
         + $past(req_tvalid && req_tready) - $past(rsp_tvalid && rsp_tready)))
      else $error("request lost or duplicated in the pipeline");
`endif

endmodule

// ===== test/tb_quaternion_multiply_rotate_unit.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the quaternion multiply and rotate unit.
module tb_quaternion_multiply_rotate_unit;
   import qmru_pkg::*;

   localparam int RANDOM_ITEMS = 1450;
   localparam int TAIL_ITEMS = 150;
   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;

   localparam data_type Q_MAX = data_type'((1 << (DATA_WIDTH - 1)) - 1);
   localparam data_type Q_MIN = data_type'(-(1 << (DATA_WIDTH - 1)));
   localparam data_type Q_ONE = data_type'(1 << FRAC_BITS);
   localparam data_type Q_HALF_SQRT2 = data_type'(11585);

   // Operand fields of one request; a_w sits in the lowest bits.
   typedef struct packed {
      data_type b_z;
      data_type b_y;
      data_type b_x;
      data_type b_w;
      data_type a_z;
      data_type a_y;
      data_type a_x;
      data_type a_w;
   } operand_set_type;

   // One request as queued for the driver; drain holds it back until all results are in.
   typedef struct packed {
      logic            drain;
      op_type          op;
      operand_set_type ops;
   } qreq_type;

   // One result: nine components with res_0 in the lowest bits, plus the saturation flag.
   typedef struct packed {
      logic                      sat;
      data_type [NUM_RES-1:0]    res;
   } qres_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from the lowest bit up
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   // req_type
   logic [REQ_TUSER_WIDTH-1:0] req_tuser = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // res_0 through res_8 from the lowest bit up
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   // sat_flag
   logic [RSP_TUSER_WIDTH-1:0] rsp_tuser;

   qreq_type pending_requests[$];
   qres_type awaited_results[$];
   int       sent_count = 0;
   int       got_count = 0;
   int       mismatch_count = 0;
   int       quiet_cycles = 0;
   int       send_gap = 0;
   int       recv_gap = 0;

   quaternion_multiply_rotate_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Round to nearest with ties upward, drop the fraction bits and clamp to the data range.
   function automatic data_type round_and_clamp(input longint acc, inout logic sat);
      longint r;
      r = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > longint'(Q_MAX)) begin
         sat = 1'b1;
         return Q_MAX;
      end else if (r < longint'(Q_MIN)) begin
         sat = 1'b1;
         return Q_MIN;
      end
      return data_type'(r);
   endfunction

   // Hamilton product p*q with every component rounded and clamped.
   function automatic void hamilton(input longint pw, input longint px, input longint py,
                                    input longint pz, input longint qw, input longint qx,
                                    input longint qy, input longint qz,
                                    output data_type ow, output data_type ox,
                                    output data_type oy, output data_type oz,
                                    inout logic sat);
      ow = round_and_clamp(pw * qw - px * qx - py * qy - pz * qz, sat);
      ox = round_and_clamp(pw * qx + px * qw + py * qz - pz * qy, sat);
      oy = round_and_clamp(pw * qy - px * qz + py * qw + pz * qx, sat);
      oz = round_and_clamp(pw * qz + px * qy - py * qx + pz * qw, sat);
   endfunction

   // Rotation matrix entry: an optional one plus twice each signed product.
   function automatic data_type rot_entry(input logic with_one, input longint t1,
                                          input longint t2, inout logic sat);
      longint acc;
      acc = with_one ? (64'sd1 <<< (2 * FRAC_BITS)) : 64'sd0;
      acc = acc + 2 * t1 + 2 * t2;
      return round_and_clamp(acc, sat);
   endfunction

   // Expected result of one request.
   function automatic qres_type compute_quat_result(input qreq_type q);
      qres_type r;
      longint   aw, ax, ay, az, bw, bx, by, bz;
      data_type tw, tx, ty, tz, ow, ox, oy, oz;
      logic     sat;
      r = '0;
      sat = 1'b0;
      aw = q.ops.a_w;
      ax = q.ops.a_x;
      ay = q.ops.a_y;
      az = q.ops.a_z;
      bw = q.ops.b_w;
      bx = q.ops.b_x;
      by = q.ops.b_y;
      bz = q.ops.b_z;
      case (q.op)
         OP_PRODUCT: begin
            hamilton(aw, ax, ay, az, bw, bx, by, bz, ow, ox, oy, oz, sat);
            r.res[0] = ow;
            r.res[1] = ox;
            r.res[2] = oy;
            r.res[3] = oz;
         end
         OP_ROTATE: begin
            // The intermediate a*v is itself rounded and clamped before the conjugate.
            hamilton(aw, ax, ay, az, 0, bx, by, bz, tw, tx, ty, tz, sat);
            hamilton(tw, tx, ty, tz, aw, -ax, -ay, -az, ow, ox, oy, oz, sat);
            r.res[0] = ox;
            r.res[1] = oy;
            r.res[2] = oz;
         end
         OP_MATRIX: begin
            r.res[0] = rot_entry(1'b1, -ay * ay, -az * az, sat);
            r.res[1] = rot_entry(1'b0, ax * ay, -aw * az, sat);
            r.res[2] = rot_entry(1'b0, ax * az, aw * ay, sat);
            r.res[3] = rot_entry(1'b0, ax * ay, aw * az, sat);
            r.res[4] = rot_entry(1'b1, -ax * ax, -az * az, sat);
            r.res[5] = rot_entry(1'b0, ay * az, -aw * ax, sat);
            r.res[6] = rot_entry(1'b0, ax * az, -aw * ay, sat);
            r.res[7] = rot_entry(1'b0, ay * az, aw * ax, sat);
            r.res[8] = rot_entry(1'b1, -ax * ax, -ay * ay, sat);
         end
         default: begin
         end
      endcase
      r.sat = sat;
      return r;
   endfunction

   function automatic qreq_type make_request(input op_type op, input data_type aw,
                                             input data_type ax, input data_type ay,
                                             input data_type az, input data_type bw,
                                             input data_type bx, input data_type by,
                                             input data_type bz);
      qreq_type q;
      q.drain = 1'b0;
      q.op = op;
      q.ops.a_w = aw;
      q.ops.a_x = ax;
      q.ops.a_y = ay;
      q.ops.a_z = az;
      q.ops.b_w = bw;
      q.ops.b_x = bx;
      q.ops.b_y = by;
      q.ops.b_z = bz;
      return q;
   endfunction

   // Component values weighted toward the extremes and the unit range.
   function automatic data_type draw_component();
      case ($urandom_range(0, 9))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return data_type'(int'($urandom_range(0, 2)) - 1);
         3, 4, 5: return data_type'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
         default: return data_type'($urandom);
      endcase
   endfunction

   task automatic note_mismatch(input string what, input longint want_v, input longint got_v);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
      end
      mismatch_count++;
   endtask

   // Request driver: presents the head of the pending queue and records its expected result.
   always @(posedge clock) begin : drive_requests
      logic present;
      logic idling;
      if (!reset && !(req_tvalid && !req_tready)) begin
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(compute_quat_result(pending_requests[0]));
            void'(pending_requests.pop_front());
            sent_count++;
         end
         idling = (pending_requests.size() > TAIL_ITEMS) && ((sent_count / 80) % 3 != 1);
         present = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_requests.size() == 0) begin
            present = 1'b0;
         end else if (pending_requests[0].drain && awaited_results.size() != 0) begin
            present = 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 4);
         end else begin
            present = 1'b1;
            req_tdata <= pending_requests[0].ops;
            req_tuser <= pending_requests[0].op;
         end
         req_tvalid <= present;
      end
   end

   // Result monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      qres_type got;
      qres_type want;
      logic     idling;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.res = rsp_tdata;
            got.sat = rsp_tuser[0];
            got_count++;
            if (awaited_results.size() == 0) begin
               note_mismatch("result with nothing awaited", 0, 1);
            end else begin
               want = awaited_results.pop_front();
               for (int k = 0; k < NUM_RES; k++) begin
                  if (got.res[k] !== want.res[k]) begin
                     note_mismatch($sformatf("res_%0d", k), want.res[k], got.res[k]);
                  end
               end
               if (got.sat !== want.sat) begin
                  note_mismatch("sat_flag", want.sat, got.sat);
               end
            end
         end
         idling = (pending_requests.size() > TAIL_ITEMS) && ((got_count / 70) % 3 != 2);
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Count cycles in which neither side moves anything.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      qreq_type q;
      logic     timed_out;
      timed_out = 1'b0;

      // Zeros, all-maximum and all-minimum operands for each operation.
      pending_requests.push_back(make_request(OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_ROTATE, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_MATRIX, 0, 0, 0, 0, 0, 0, 0, 0));
      for (int k = 0; k < 3; k++) begin
         pending_requests.push_back(make_request(op_type'(k), Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                                 Q_MAX, Q_MAX, Q_MAX, Q_MAX));
         pending_requests.push_back(make_request(op_type'(k), Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                                 Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      end
      pending_requests.push_back(make_request(OP_PRODUCT, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                              Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      // Identity rotation with a nonzero scalar in b, which must be ignored.
      pending_requests.push_back(make_request(OP_ROTATE, Q_ONE, 0, 0, 0,
                                              Q_MAX, 1000, -2000, 3000));
      // Quarter turn about z, as a rotation and as a matrix.
      pending_requests.push_back(make_request(OP_ROTATE, Q_HALF_SQRT2, 0, 0, Q_HALF_SQRT2,
                                              5, Q_ONE, 0, 0));
      pending_requests.push_back(make_request(OP_MATRIX, Q_HALF_SQRT2, 0, 0, Q_HALF_SQRT2,
                                              Q_MIN, 7, 8, 9));
      // Rounding ties: plus one half, minus one half, minus one and a half.
      pending_requests.push_back(make_request(OP_PRODUCT, 1, 0, 0, 0, 8192, 0, 0, 0));
      pending_requests.push_back(make_request(OP_PRODUCT, 1, 0, 0, 0, -8192, 0, 0, 0));
      pending_requests.push_back(make_request(OP_PRODUCT, 1, 0, 0, 0, -24576, 0, 0, 0));
      // Saturation of the rotation intermediate and of a diagonal matrix entry.
      pending_requests.push_back(make_request(OP_ROTATE, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                                              0, Q_MIN, Q_MIN, Q_MIN));
      pending_requests.push_back(make_request(OP_MATRIX, 0, Q_MIN, 0, 0, 0, 0, 0, 0));
      // Unknown operation code yields an all-zero result.
      pending_requests.push_back(make_request(OP_NONE, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                              Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      pending_requests.push_back(make_request(OP_NONE, draw_component(), draw_component(),
                                              draw_component(), draw_component(),
                                              draw_component(), draw_component(),
                                              draw_component(), draw_component()));

      // Random requests; two of them wait for the pipeline to empty first.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         q = make_request(($urandom_range(0, 15) == 0) ? OP_NONE
                                                       : op_type'($urandom_range(0, 2)),
                          draw_component(), draw_component(), draw_component(),
                          draw_component(), draw_component(), draw_component(),
                          draw_component(), draw_component());
         q.drain = (n == 0) || (n == RANDOM_ITEMS / 2);
         pending_requests.push_back(q);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while ((pending_requests.size() != 0 || awaited_results.size() != 0) && !timed_out) begin
         @(posedge clock);
         timed_out = (quiet_cycles >= QUIET_LIMIT);
      end

      if (timed_out) begin
         $display("TB_ERROR");
      end else begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("TB_OK");
         end else begin
            $display("TB_ERROR");
         end
      end
      $finish;
   end

endmodule
